// ===== sv/mcit_pkg.sv =====
// shared types, codes and defaults for the multi-channel interval timer
`timescale 1ns / 1ps

package mcit_pkg;

  // default bank size and counter width
  localparam int NUM_CHANNELS_DEF = 8;
  localparam int TIME_WIDTH_DEF   = 32;

  // fixed field widths of the stream and config words
  localparam int CHAN_W     = 3;
  localparam int PERIOD_W   = 32;
  localparam int CMD_W      = 3;
  localparam int MASK_W     = 8;
  localparam int OUT_TIME_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 8;

  // command codes carried in tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_POLL    = 3'd3,
    CMD_REMOVE  = 3'd4
  } cmd_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CALLBACK  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTORESET = 8'd1;

  // register reset values
  localparam logic [MASK_W-1:0] CALLBACK_RST  = 8'h00;
  localparam logic [MASK_W-1:0] AUTORESET_RST = 8'hFF;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_TICK = 5'b00100,
    S_SCAN = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  // per-channel bit of an eight-bit register; channels eight and above have none
  function automatic logic reg_bit(input logic [MASK_W-1:0] mask, input logic [5:0] ch);
    logic hit;
    hit = 1'b0;
    if (ch < 6'd8) begin
      hit = mask[ch[2:0]];
    end
    return hit;
  endfunction

endpackage

// ===== sv/multi_channel_interval_timer_unit.sv =====
// top level of the multi-channel interval timer: sequencer, channel scan and stream ports
`timescale 1ns / 1ps

// Bank of interval timers sharing one tick counter that advances on each tick command.
// Input channel (in_*): one word per command. in_tuser holds the command code
// (tick, load, restart, poll, remove); in_tdata holds channel and period.
// Output channel (out_*): exactly one word per command, carrying poll_done,
// fired_mask and the counter value after the command.
// Config channel (cfg_*): index 0 writes callback_mask, index 1 autoreset_mask,
// other indexes are ignored; always ready, write only while idle.
// Sequence: a word is captured into the command, channel and period registers on
// accept; load, restart, poll, remove and unknown codes then execute in the exec
// state, while a tick advances the counter in the tick state and then scans the
// channels through one shared subtract-and-compare unit at one channel a cycle.
// The response state then writes the result to the output register, waiting while
// that register is still held, and in_tready returns as out_tvalid rises.
// in_tready is high only while the sequencer is idle.
// A stalled receiver holds the output register; the block still takes the
// next word and waits before its own result until the register frees up.
// Reset (rst_n low, synchronous) zeroes the counter, disables all channels,
// sets callback_mask to 0 and autoreset_mask to all ones.
module multi_channel_interval_timer_unit #(
  parameter int NUM_CHANNELS = mcit_pkg::NUM_CHANNELS_DEF,
  parameter int TIME_WIDTH   = mcit_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mcit_pkg::IN_DATA_W-1:0]  in_tdata,   // channel[2:0], period[34:3], zero pad
  input  logic [mcit_pkg::CMD_W-1:0]      in_tuser,   // command[2:0]
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mcit_pkg::OUT_DATA_W-1:0] out_tdata,  // poll_done[0], fired_mask[8:1],
                                                      // current_time[40:9], zero pad
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mcit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcit_pkg::MASK_W-1:0]     cfg_wdata
);

  import mcit_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // sequencer and control state
  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [CHAN_W-1:0]      chan_r, chan_nxt;
  logic [PERIOD_W-1:0]    period_r, period_nxt;
  logic [CH_W-1:0]        idx_r, idx_nxt;
  logic [TIME_WIDTH-1:0]  now_r, now_nxt;
  logic [NUM_CHANNELS-1:0] done_r, done_nxt;
  logic [NUM_CHANNELS-1:0] en_r, en_nxt;
  logic [NUM_CHANNELS-1:0] st_vld_r, st_vld_nxt;
  logic [NUM_CHANNELS-1:0] per_vld_r, per_vld_nxt;
  logic                   poll_r, poll_nxt;
  logic [MASK_W-1:0]      fired_r, fired_nxt;
  logic [MASK_W-1:0]      cb_r, cb_nxt;
  logic [MASK_W-1:0]      ar_r, ar_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  // channel memories
  logic [TIME_WIDTH-1:0]  start_mem [NUM_CHANNELS];
  logic [TIME_WIDTH-1:0]  period_mem [NUM_CHANNELS];
  logic [TIME_WIDTH-1:0]  st_rd_r;
  logic [TIME_WIDTH-1:0]  per_rd_r;
  logic [CH_W-1:0]        rd_addr;
  logic                   st_we;
  logic [CH_W-1:0]        st_waddr;
  logic                   per_we;
  logic [TIME_WIDTH-1:0]  per_wdata;

  // datapath helpers
  logic                   in_acc;
  logic                   ch_ok;
  logic [5:0]             ch_w;
  logic [CH_W-1:0]        ch_idx;
  logic [5:0]             idx_w;
  logic                   scan_last;
  logic [TIME_WIDTH-1:0]  st_val;
  logic [TIME_WIDTH-1:0]  per_val;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   hit;
  logic [63:0]            now_ext;
  logic [63:0]            per_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // addressed channel decode
  assign ch_ok  = (32'(chan_r) < NUM_CHANNELS);
  assign ch_w   = 6'(chan_r);
  assign ch_idx = ch_w[CH_W-1:0];
  assign idx_w  = 6'(idx_r);
  assign scan_last = (32'(idx_r) == NUM_CHANNELS - 1);

  assign now_ext   = 64'(now_r);
  assign per_ext   = 64'(period_r);
  assign per_wdata = per_ext[TIME_WIDTH-1:0];

  // shared compare unit: wrapping elapsed time against the period
  assign st_val  = st_vld_r[idx_r] ? st_rd_r : '0;
  assign per_val = per_vld_r[idx_r] ? per_rd_r : '0;
  assign elapsed = now_r - st_val;
  assign hit     = en_r[idx_r] && !done_r[idx_r] && (elapsed >= per_val);

  // sequencer and state updates
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    chan_nxt      = chan_r;
    period_nxt    = period_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    done_nxt      = done_r;
    en_nxt        = en_r;
    st_vld_nxt    = st_vld_r;
    per_vld_nxt   = per_vld_r;
    poll_nxt      = poll_r;
    fired_nxt     = fired_r;
    cb_nxt        = cb_r;
    ar_nxt        = ar_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_addr       = '0;
    st_we         = 1'b0;
    st_waddr      = ch_idx;
    per_we        = 1'b0;

    // configuration writes
    if (cfg_valid) begin
      if (cfg_index == REG_CALLBACK) begin
        cb_nxt = cfg_wdata;
      end else if (cfg_index == REG_AUTORESET) begin
        ar_nxt = cfg_wdata;
      end
    end

    // output register drains
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = cmd_t'(in_tuser);
          chan_nxt   = in_tdata[2:0];
          period_nxt = in_tdata[34:3];
          poll_nxt   = 1'b0;
          fired_nxt  = '0;
          state_nxt  = (cmd_t'(in_tuser) == CMD_TICK) ? S_TICK : S_EXEC;
        end
      end
      S_TICK: begin
        now_nxt   = now_r + TIME_WIDTH'(1);
        idx_nxt   = '0;
        rd_addr   = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rd_addr = scan_last ? idx_r : idx_r + CH_W'(1);
        if (hit) begin
          done_nxt[idx_r] = 1'b1;
          if (reg_bit(cb_r, idx_w)) begin
            done_nxt[idx_r]      = 1'b0;
            fired_nxt[idx_w[2:0]] = 1'b1;
            if (reg_bit(ar_r, idx_w)) begin
              st_we               = 1'b1;
              st_waddr            = idx_r;
              st_vld_nxt[idx_r]   = 1'b1;
            end
          end
        end
        if (scan_last) begin
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx_r + CH_W'(1);
        end
      end
      S_EXEC: begin
        if (ch_ok) begin
          unique case (cmd_r)
            CMD_LOAD: begin
              en_nxt[ch_idx]      = 1'b1;
              done_nxt[ch_idx]    = 1'b0;
              per_we              = 1'b1;
              per_vld_nxt[ch_idx] = 1'b1;
              st_we               = 1'b1;
              st_vld_nxt[ch_idx]  = 1'b1;
            end
            CMD_RESTART: begin
              st_we              = 1'b1;
              st_vld_nxt[ch_idx] = 1'b1;
            end
            CMD_POLL: begin
              if (done_r[ch_idx]) begin
                done_nxt[ch_idx] = 1'b0;
                poll_nxt         = 1'b1;
                if (reg_bit(ar_r, ch_w)) begin
                  st_we              = 1'b1;
                  st_vld_nxt[ch_idx] = 1'b1;
                end
              end
            end
            CMD_REMOVE: begin
              en_nxt[ch_idx] = 1'b0;
            end
            default: begin
              // tick never reaches here; unknown codes change nothing
            end
          endcase
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {7'd0, now_ext[OUT_TIME_W-1:0], fired_r, poll_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      now_r       <= '0;
      done_r      <= '0;
      en_r        <= '0;
      st_vld_r    <= '0;
      per_vld_r   <= '0;
      cb_r        <= CALLBACK_RST;
      ar_r        <= AUTORESET_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      now_r       <= now_nxt;
      done_r      <= done_nxt;
      en_r        <= en_nxt;
      st_vld_r    <= st_vld_nxt;
      per_vld_r   <= per_vld_nxt;
      cb_r        <= cb_nxt;
      ar_r        <= ar_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    chan_r     <= chan_nxt;
    period_r   <= period_nxt;
    poll_r     <= poll_nxt;
    fired_r    <= fired_nxt;
    out_data_r <= out_data_nxt;
  end

  // start time memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      start_mem[st_waddr] <= now_r;
    end
    st_rd_r <= start_mem[rd_addr];
  end

  // period memory: written by load, read by the scan
  always_ff @(posedge clk) begin
    if (per_we) begin
      period_mem[ch_idx] <= per_wdata;
    end
    per_rd_r <= period_mem[rd_addr];
  end

endmodule
